/* rtl/ptb_pkg.sv */
package ptb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MODE_W     = 3;
    localparam int TIDX_W     = 4;
    localparam int PERIOD_W   = 16;
    localparam int MASK_W     = 16;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 18;
    localparam int BIG_STEP   = 10;

    localparam logic [MODE_W-1:0] MODE_TICK1  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TICK10 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ENABLE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESUME = 3'd4;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic load;
        logic apply;
        logic scan;
        t_idx scan_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic in_tick;
    } t_dp_status;

    function automatic t_idx to_idx(input logic [TIDX_W-1:0] ti);
        logic [IDX_W+TIDX_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, ti};
        return wide[IDX_W-1:0];
    endfunction

endpackage

/* rtl/periodic_timer_bank_core.sv */
// Bank of periodic countdown timers with a shared millisecond counter. Raise
// start for one cycle with busy low to hand in an item: a 1 ms or 10 ms tick,
// or an enable, stop or resume command for one timer. Exactly one result
// follows per item, shown for a single cycle with o_valid high; the receiver
// cannot stall it, so sample it on that cycle. A command passes from start
// through the command (apply) state to the result; a tick walks the timers one
// per cycle through the single count/period register port before its result.
// busy stays high until the result cycle has passed.
module periodic_timer_bank_core
    import ptb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [TIDX_W-1:0]   i_timer_index,
    input  logic [PERIOD_W-1:0] i_period_ms,
    output logic                o_valid,
    output logic [MASK_W-1:0]   o_fired_mask,
    output logic [MASK_W-1:0]   o_running_mask,
    output logic [TIME_W-1:0]   o_elapsed_ms
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       ctrl_busy;
    logic       go;

    assign go   = start && !ctrl_busy;
    assign busy = ctrl_busy;

    ptb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (go),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .busy     (ctrl_busy),
        .o_valid  (o_valid)
    );

    ptb_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_mode         (i_mode),
        .i_timer_index  (i_timer_index),
        .i_period_ms    (i_period_ms),
        .o_status       (dp_status),
        .o_fired_mask   (o_fired_mask),
        .o_running_mask (o_running_mask),
        .o_elapsed_ms   (o_elapsed_ms)
    );

endmodule

/* rtl/ptb_ctrl.sv */
module ptb_ctrl
    import ptb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       busy,
    output logic       o_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    localparam t_idx LAST_IDX = t_idx'(NUM_TIMERS - 1);

    logic [1:0] r_state, n_state;
    t_idx       r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = i_status.in_tick ? S_SCAN : S_CMD;
                end
            end
            S_CMD: begin
                o_cmd.apply = 1'b1;
                n_state     = S_RESP;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_RESP;
                end else begin
                    n_idx = r_idx + t_idx'(1);
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.scan_idx = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_RESP);

endmodule

/* rtl/ptb_datapath.sv */
module ptb_datapath
    import ptb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [TIDX_W-1:0]   i_timer_index,
    input  logic [PERIOD_W-1:0] i_period_ms,
    output t_dp_status          o_status,
    output logic [MASK_W-1:0]   o_fired_mask,
    output logic [MASK_W-1:0]   o_running_mask,
    output logic [TIME_W-1:0]   o_elapsed_ms
);

    logic [MODE_W-1:0]        r_mode;
    t_idx                     r_tidx;
    logic                     r_hit;
    logic                     r_big;
    logic [PERIOD_W-1:0]      r_new_period;
    logic [TIME_W-1:0]        r_ms;
    logic [NUM_TIMERS-1:0]    r_run;
    logic [NUM_TIMERS-1:0]    r_fired;
    logic [PERIOD_W-1:0]      r_period [NUM_TIMERS];
    logic signed [COUNT_W-1:0] r_count [NUM_TIMERS];

    logic                      in_tick;
    logic signed [COUNT_W-1:0] step;
    logic signed [COUNT_W-1:0] cur_count;
    logic signed [COUNT_W-1:0] diff;
    logic signed [COUNT_W-1:0] reload;
    logic signed [COUNT_W-1:0] new_load;

    assign in_tick           = (i_mode == MODE_TICK1) || (i_mode == MODE_TICK10);
    assign o_status.in_tick  = in_tick;

    assign step      = r_big ? COUNT_W'(BIG_STEP) : COUNT_W'(1);
    assign cur_count = r_count[i_cmd.scan_idx];
    assign diff      = cur_count - step;
    assign reload    = $signed({2'b00, r_period[i_cmd.scan_idx]}) - COUNT_W'(1);
    assign new_load  = $signed({2'b00, r_new_period}) - COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms    <= '0;
            r_run   <= '0;
            r_fired <= '0;
            r_big   <= 1'b0;
            r_mode  <= MODE_TICK1;
            r_hit   <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_period[i] <= '0;
                r_count[i]  <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_mode       <= i_mode;
                r_tidx       <= to_idx(i_timer_index);
                r_hit        <= (32'(i_timer_index) < NUM_TIMERS);
                r_new_period <= i_period_ms;
                r_big        <= (i_mode == MODE_TICK10);
                r_fired      <= '0;
                if (in_tick) begin
                    r_ms <= r_ms + ((i_mode == MODE_TICK10) ? TIME_W'(BIG_STEP) : TIME_W'(1));
                end
            end
            if (i_cmd.apply && r_hit) begin
                unique case (r_mode)
                    MODE_ENABLE: begin
                        r_period[r_tidx] <= r_new_period;
                        r_count[r_tidx]  <= new_load;
                        r_run[r_tidx]    <= 1'b1;
                    end
                    MODE_STOP: begin
                        r_run[r_tidx] <= 1'b0;
                    end
                    MODE_RESUME: begin
                        r_run[r_tidx] <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.scan && r_run[i_cmd.scan_idx]) begin
                if (diff < 0) begin
                    r_fired[i_cmd.scan_idx] <= 1'b1;
                    r_count[i_cmd.scan_idx] <= reload;
                end else begin
                    r_count[i_cmd.scan_idx] <= diff;
                end
            end
        end
    end

    always_comb begin
        o_fired_mask   = '0;
        o_running_mask = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < NUM_TIMERS) begin
                o_fired_mask[i]   = r_fired[i];
                o_running_mask[i] = r_run[i];
            end
        end
    end

    assign o_elapsed_ms = r_ms;

endmodule
